[src/humidity_sensor_frame_decoder_defines.svh]
// ----------------------------------------------------------------------------
// humidity sensor frame decoder assertion macros
// shared property wrappers for the checker, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH

// plain property, disabled while reset is asserted
`define HSFD_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication built on the plain form
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
  `HSFD_ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

[src/hsfd_pkg.sv]
// ----------------------------------------------------------------------------
// hsfd_pkg
// payload types, frame positions, conversion constants and the crc-8 step
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

  // byte positions inside a measurement frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;

  localparam logic [28:0] TEMP_MUL    = 29'd4375;
  localparam int unsigned TEMP_SHIFT  = 14;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [25:0] HUM_MUL     = 26'd625;
  localparam int unsigned HUM_SHIFT   = 12;
  localparam logic [13:0] HUM_MAX     = 14'd9999;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } hsfd_in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        humidity_centi;
    logic               temp_crc_bad;
    logic               hum_crc_bad;
  } hsfd_out_t;

  // one byte through the msb-first crc-8 shift register
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/humidity_sensor_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// crc-checked six-byte temperature/humidity frame to scaled result
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid_i / in_stall_o / in_data_i) takes one frame byte
//   per transfer: temp msb, lsb, crc, then hum msb, lsb, crc
// - frame_start on a byte makes it the temp msb and drops any partial frame
// - output channel (out_valid_o / out_stall_i / out_data_o) gives one result
//   per complete frame, after the humidity crc byte
// - latency: the result is valid in the cycle after the sixth byte transfer
// - throughput: one byte per cycle while in_stall_o is low; the crc step and both
//   constant multiplies sit in a single stage in front of the output register
// - a result waiting in the output register while out_stall_i is high holds
//   in_stall_o high; with the output free, bytes go in every cycle
// - reset clears the byte position, the crc to all ones, the assembled
//   words and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hsfd_pkg::hsfd_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hsfd_pkg::hsfd_out_t     out_data_o
);

  // frame state
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_raw_q, temp_raw_d;
  logic [15:0] hum_raw_q, hum_raw_d;
  logic        temp_fail_q, temp_fail_d;

  // output register
  logic                out_valid_q;
  hsfd_pkg::hsfd_out_t out_data_q;
  hsfd_pkg::hsfd_out_t result;

  logic       in_xfer;
  logic       produce;
  logic [2:0] pos_eff;
  logic [7:0] b;

  // conversion datapath
  logic [28:0] t_prod;
  logic [15:0] t_centi;
  logic [25:0] h_prod;

  // hold the input only while a finished result is blocked downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign b          = in_data_i.rx_byte;

  // frame_start restarts the frame; unreachable positions behave as the first byte
  always_comb begin
    if (in_data_i.frame_start || pos_q > hsfd_pkg::POS_H_CRC) begin
      pos_eff = hsfd_pkg::POS_T_MSB;
    end else begin
      pos_eff = pos_q;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_raw_d  = temp_raw_q;
    hum_raw_d   = hum_raw_q;
    temp_fail_d = temp_fail_q;
    produce     = 1'b0;
    if (in_xfer) begin
      pos_d = (pos_eff == hsfd_pkg::POS_H_CRC) ? hsfd_pkg::POS_T_MSB : pos_eff + 3'd1;
      unique case (pos_eff)
        hsfd_pkg::POS_T_MSB: begin
          temp_raw_d = {b, 8'h00};
          crc_d      = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, b);
        end
        hsfd_pkg::POS_T_LSB: begin
          temp_raw_d = {temp_raw_q[15:8], b};
          crc_d      = hsfd_pkg::crc8_update(crc_q, b);
        end
        hsfd_pkg::POS_T_CRC: begin
          temp_fail_d = (b != crc_q);
          crc_d       = hsfd_pkg::CRC_INIT;
        end
        hsfd_pkg::POS_H_MSB: begin
          hum_raw_d = {b, 8'h00};
          crc_d     = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, b);
        end
        hsfd_pkg::POS_H_LSB: begin
          hum_raw_d = {hum_raw_q[15:8], b};
          crc_d     = hsfd_pkg::crc8_update(crc_q, b);
        end
        hsfd_pkg::POS_H_CRC: begin
          crc_d   = hsfd_pkg::CRC_INIT;
          produce = 1'b1;
        end
        default: begin
          pos_d = hsfd_pkg::POS_T_MSB;
        end
      endcase
    end
  end

  // both words are already registered when the humidity crc byte arrives
  assign t_prod  = 29'(temp_raw_q) * hsfd_pkg::TEMP_MUL;
  assign t_centi = {1'b0, t_prod[28:hsfd_pkg::TEMP_SHIFT]} - hsfd_pkg::TEMP_OFFSET;
  assign h_prod  = 26'(hum_raw_q) * hsfd_pkg::HUM_MUL;

  always_comb begin
    result.temp_centi     = $signed(t_centi[14:0]);
    result.humidity_centi = h_prod[25:hsfd_pkg::HUM_SHIFT];
    result.temp_crc_bad   = temp_fail_q;
    result.hum_crc_bad    = (b != crc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= hsfd_pkg::POS_T_MSB;
      crc_q       <= hsfd_pkg::CRC_INIT;
      temp_raw_q  <= '0;
      hum_raw_q   <= '0;
      temp_fail_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_raw_q  <= temp_raw_d;
      hum_raw_q   <= hum_raw_d;
      temp_fail_q <= temp_fail_d;
      if (produce) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only, loaded with each new result
  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[src/hsfd_checker.sv]
// ----------------------------------------------------------------------------
// hsfd_checker
// port-level checks for the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_sensor_frame_decoder_defines.svh"

module hsfd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire hsfd_pkg::hsfd_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire hsfd_pkg::hsfd_out_t out_data_o
);

  // a stalled byte stays and keeps its payload
  `HSFD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(in_data_i), "input byte dropped or changed while stalled")

  // a blocked result stays and keeps its payload
  `HSFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // input is held back only by a blocked result
  `HSFD_ASSERT_PROP(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i),
    "input stalled without a blocked result")

  // every fresh result follows an input transfer
  `HSFD_ASSERT_PROP(a_out_source,
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(in_valid_i && !in_stall_o),
    "result without a preceding input transfer")

  // humidity conversion never exceeds full scale
  `HSFD_ASSERT_PROP(a_hum_range,
    out_valid_o |-> (out_data_o.humidity_centi <= hsfd_pkg::HUM_MAX),
    "humidity out of range")

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);

`default_nettype wire
